// ===== design/rtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtm_pkg: shared constants and tables for the thruster mixer
// widths, pulse-width constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package rtm_pkg;

	localparam int IN_W      = 10;   // joystick field width
	localparam int OUT_W     = 11;   // pulse channel width
	localparam int CORDIC_N  = 30;   // cordic iterations
	localparam int XY_W      = 34;   // cordic vector width
	localparam int ANG_W     = 32;   // q30 quarter-turn accumulator
	localparam int PRE_SHIFT = 20;   // target pre-scale
	localparam int DEN_W     = 39;   // width of (x^2+y^2)^2 and 4x^2y^2
	localparam int CENTRE_PW = 1500;
	localparam int IDLE_PW   = 400;
	localparam int CMD_LIMIT = 400;
	localparam int DEAD_BAND = 10;

	typedef logic signed [XY_W-1:0]  cxy_t;
	typedef logic signed [ANG_W-1:0] ang_t;

	// atan(2^-i) in q30 quarter turns
	function automatic ang_t atan_q30(input int i);
		ang_t a;
		case (i)
			0:  a = 32'sh20000000;
			1:  a = 32'sh12E4051E;
			2:  a = 32'sh09FB385B;
			3:  a = 32'sh051111D4;
			4:  a = 32'sh028B0D43;
			5:  a = 32'sh0145D7E1;
			6:  a = 32'sh00A2F61E;
			7:  a = 32'sh00517C55;
			8:  a = 32'sh0028BE53;
			9:  a = 32'sh00145F2F;
			10: a = 32'sh000A2F98;
			11: a = 32'sh000517CC;
			12: a = 32'sh00028BE6;
			13: a = 32'sh000145F3;
			14: a = 32'sh0000A2FA;
			15: a = 32'sh0000517D;
			16: a = 32'sh000028BE;
			17: a = 32'sh0000145F;
			18: a = 32'sh00000A30;
			19: a = 32'sh00000518;
			20: a = 32'sh0000028C;
			21: a = 32'sh00000146;
			22: a = 32'sh000000A3;
			23: a = 32'sh00000051;
			24: a = 32'sh00000029;
			25: a = 32'sh00000014;
			26: a = 32'sh0000000A;
			27: a = 32'sh00000005;
			28: a = 32'sh00000003;
			29: a = 32'sh00000001;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== design/rtm_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtm_cordic: pipelined vectoring cordic
// one iteration per stage, angle of (|dot|, |crs|) in q30 quarter turns
// ----------------------------------------------------------------------------
module rtm_cordic (
	input  logic                    clk,
	input  logic                    ce,
	input  logic signed [10:0]      dot,
	input  logic signed [10:0]      crs,
	output rtm_pkg::ang_t           angle,
	output logic                    dot_neg
);

	localparam int N = rtm_pkg::CORDIC_N;

	rtm_pkg::cxy_t x_s [N];
	rtm_pkg::cxy_t y_s [N];
	rtm_pkg::ang_t z_s [N];
	logic          neg_s [N];

	logic signed [11:0] dot_abs, crs_abs;
	assign dot_abs = dot[10] ? -12'(dot) : 12'(dot);
	assign crs_abs = crs[10] ? -12'(crs) : 12'(crs);

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_iter
			rtm_pkg::cxy_t x_in, y_in;
			rtm_pkg::ang_t z_in;
			logic          neg_in;
			if (i == 0) begin : g_first
				assign x_in   = rtm_pkg::cxy_t'(dot_abs) <<< rtm_pkg::PRE_SHIFT;
				assign y_in   = rtm_pkg::cxy_t'(crs_abs) <<< rtm_pkg::PRE_SHIFT;
				assign z_in   = '0;
				assign neg_in = dot[10];
			end else begin : g_next
				assign x_in   = x_s[i-1];
				assign y_in   = y_s[i-1];
				assign z_in   = z_s[i-1];
				assign neg_in = neg_s[i-1];
			end
			always_ff @(posedge clk) begin
				if (ce) begin
					neg_s[i] <= neg_in;
					if (!y_in[rtm_pkg::XY_W-1]) begin
						x_s[i] <= x_in + (y_in >>> i);
						y_s[i] <= y_in - (x_in >>> i);
						z_s[i] <= z_in + rtm_pkg::atan_q30(i);
					end else begin
						x_s[i] <= x_in - (y_in >>> i);
						y_s[i] <= y_in + (x_in >>> i);
						z_s[i] <= z_in - rtm_pkg::atan_q30(i);
					end
				end
			end
		end
	endgenerate

	assign angle   = z_s[N-1];
	assign dot_neg = neg_s[N-1];

endmodule

// ===== design/rtm_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtm_isqrt: pipelined integer square root
// one root bit per stage, floor of the square root
// ----------------------------------------------------------------------------
module rtm_isqrt #(
	parameter int IN_W = 36
) (
	input  logic              clk,
	input  logic              ce,
	input  logic [IN_W-1:0]   radicand,
	output logic [IN_W/2-1:0] root
);

	localparam int RB = IN_W / 2;
	localparam int RW = RB + 2;

	logic [RW-1:0]   rem_s [RB];
	logic [RB-1:0]   res_s [RB];
	logic [IN_W-1:0] rad_s [RB];

	genvar k;
	generate
		for (k = 0; k < RB; k++) begin : g_bit
			logic [RW-1:0]   rem_in, cand, trial;
			logic [RB-1:0]   res_in;
			logic [IN_W-1:0] rad_in;
			if (k == 0) begin : g_first
				assign rem_in = '0;
				assign res_in = '0;
				assign rad_in = radicand;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign res_in = res_s[k-1];
				assign rad_in = rad_s[k-1];
			end
			assign cand  = {rem_in[RW-3:0], rad_in[IN_W-1 -: 2]};
			assign trial = {res_in, 2'b01};
			always_ff @(posedge clk) begin
				if (ce) begin
					rad_s[k] <= {rad_in[IN_W-3:0], 2'b00};
					if (cand >= trial) begin
						rem_s[k] <= cand - trial;
						res_s[k] <= {res_in[RB-2:0], 1'b1};
					end else begin
						rem_s[k] <= cand;
						res_s[k] <= {res_in[RB-2:0], 1'b0};
					end
				end
			end
		end
	endgenerate

	assign root = res_s[RB-1];

endmodule

// ===== design/rtm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtm_div: pipelined restoring divider
// fractional quotient floor(num * 2^(QB-1) / den) for num <= den
// ----------------------------------------------------------------------------
module rtm_div #(
	parameter int QB = 9
) (
	input  logic                          clk,
	input  logic                          ce,
	input  logic [rtm_pkg::DEN_W-1:0]     num,
	input  logic [rtm_pkg::DEN_W-1:0]     den,
	output logic [QB-1:0]                 quot
);

	localparam int DW = rtm_pkg::DEN_W;

	logic [DW:0]   rem_s [QB];
	logic [DW-1:0] den_s [QB];
	logic [QB-1:0] q_s   [QB];

	genvar k;
	generate
		for (k = 0; k < QB; k++) begin : g_bit
			logic [DW:0]   cand;
			logic [DW-1:0] den_in;
			logic [QB-1:0] q_in;
			if (k == 0) begin : g_first
				assign cand   = {1'b0, num};
				assign den_in = den;
				assign q_in   = '0;
			end else begin : g_next
				assign cand   = {rem_s[k-1][DW-1:0], 1'b0};
				assign den_in = den_s[k-1];
				assign q_in   = q_s[k-1];
			end
			always_ff @(posedge clk) begin
				if (ce) begin
					den_s[k] <= den_in;
					if (cand >= {1'b0, den_in}) begin
						rem_s[k] <= cand - {1'b0, den_in};
						q_s[k]   <= {q_in[QB-2:0], 1'b1};
					end else begin
						rem_s[k] <= cand;
						q_s[k]   <= {q_in[QB-2:0], 1'b0};
					end
				end
			end
		end
	endgenerate

	assign quot = q_s[QB-1];

endmodule

// ===== design/rov_thruster_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rov_thruster_mixer: joystick to seven pulse-width channels
// vectored four-thruster x mixer or differential drive, fully pipelined
// ----------------------------------------------------------------------------
// Takes one joystick request per clock (strafe, surge, yaw, heave, claw) and
// returns seven 11-bit pulse values through the output register, one
// result per request, in order. There are 35 register stages: the input
// register, the 30-stage vectoring cordic that finds the angle between the
// target and each diagonal thruster axis, the stage that turns the angle into
// a signed weight, two multiplier stages and the output register. The square
// root of the target length and the heading-shaping divider run alongside the
// cordic and are delayed to meet it. The whole pipeline holds while a finished
// result waits, so a stalled output loses nothing; a new request is taken in
// every cycle that the output is empty or being taken. vehicle_type selects
// vectored (0) or differential (1) mixing and must only be written while the
// block is idle. Fixed point uses FRACTION_BITS fractional bits (4 to 16),
// truncating.
// ----------------------------------------------------------------------------
module rov_thruster_mixer #(
	parameter int FRACTION_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,   // vehicle_type
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,       // strafe_right, surge_forward, yaw_clockwise,
	                                   // heave_up, claw_command (10 bits each), zero pad
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata        // channel_zero .. channel_six (11 bits each), zero pad
);

	localparam int F      = FRACTION_BITS;
	localparam int SQ_W   = 2 * F + 20;          // radicand width
	localparam int RQ_W   = SQ_W / 2;            // root width
	localparam int QB     = F + 1;               // quotient width
	localparam int LAT    = 35;                  // request to result register
	localparam int JOIN   = 32;                  // stage where the three paths meet
	localparam int RQ_DLY = JOIN - (RQ_W + 3);
	localparam int QT_DLY = JOIN - (QB + 4);
	localparam int CMD_DLY = 33;                 // s1 to s34
	localparam int P1_W   = F + 1 + RQ_W;
	localparam int SQ2_W  = F + 2;
	localparam int P2_W   = P1_W + SQ2_W;
	localparam int IW     = rtm_pkg::IN_W;

	typedef struct packed {
		logic signed [IW-1:0] x;
		logic signed [IW-1:0] y;
		logic signed [IW-1:0] yaw;
		logic signed [IW-1:0] up;
		logic signed [IW-1:0] claw;
		logic                 dz;
	} cmd_t;

	// saturate a motor term to the command limit
	function automatic logic signed [13:0] sat400(input logic signed [13:0] v);
		logic signed [13:0] r;
		if (v > 14'sd400)
			r = 14'sd400;
		else if (v < -14'sd400)
			r = -14'sd400;
		else
			r = v;
		return r;
	endfunction

	// ---------------- control
	logic            vtype_q;
	logic [LAT:1]    vld_s;
	logic            ce;

	assign ce       = !vld_s[LAT] || m_tready;
	assign s_tready = ce;
	assign m_tvalid = vld_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtype_q <= 1'b0;
			vld_s   <= '0;
		end else begin
			if (cfg_wr_en)
				vtype_q <= cfg_wr_data;
			if (ce)
				vld_s <= {vld_s[LAT-1:1], s_tvalid};
		end
	end

	// ---------------- stage 1: register the request
	logic signed [IW-1:0] x_s1, y_s1, yaw_s1, up_s1, claw_s1;

	always_ff @(posedge clk) begin
		if (ce) begin
			x_s1    <= s_tdata[9:0];
			y_s1    <= s_tdata[19:10];
			yaw_s1  <= s_tdata[29:20];
			up_s1   <= s_tdata[39:30];
			claw_s1 <= s_tdata[49:40];
		end
	end

	// dead zone when both axes are small
	logic dz_s1;
	assign dz_s1 = (x_s1 > -10'(rtm_pkg::DEAD_BAND)) && (x_s1 < 10'(rtm_pkg::DEAD_BAND))
	            && (y_s1 > -10'(rtm_pkg::DEAD_BAND)) && (y_s1 < 10'(rtm_pkg::DEAD_BAND));

	// diagonal axes: a along (1,1), b along (-1,1)
	logic signed [10:0] sum_xy, dif_yx;
	assign sum_xy = 11'(x_s1) + 11'(y_s1);
	assign dif_yx = 11'(y_s1) - 11'(x_s1);

	rtm_pkg::ang_t ang_a, ang_b;
	logic          neg_a, neg_b;

	rtm_cordic u_cordic_a (
		.clk(clk), .ce(ce), .dot(sum_xy), .crs(dif_yx), .angle(ang_a), .dot_neg(neg_a)
	);
	rtm_cordic u_cordic_b (
		.clk(clk), .ce(ce), .dot(dif_yx), .crs(sum_xy), .angle(ang_b), .dot_neg(neg_b)
	);

	// ---------------- stages 2..4: squares, radius squared, shaping operands
	logic signed [19:0] xx, yy;
	logic [18:0] x2_s2, y2_s2;
	logic [19:0] r2_s3;
	logic [36:0] xy2_s3;
	logic [rtm_pkg::DEN_W-1:0] num_s4, den_s4;
	logic [37:0] xy2_full;
	logic [39:0] r4_full;

	assign xx       = x_s1 * x_s1;
	assign yy       = y_s1 * y_s1;
	assign xy2_full = x2_s2 * y2_s2;
	assign r4_full  = r2_s3 * r2_s3;

	always_ff @(posedge clk) begin
		if (ce) begin
			x2_s2  <= xx[18:0];
			y2_s2  <= yy[18:0];
			r2_s3  <= 20'(x2_s2) + 20'(y2_s2);
			xy2_s3 <= xy2_full[36:0];
			num_s4 <= {xy2_s3, 2'b00};
			den_s4 <= r4_full[rtm_pkg::DEN_W-1:0];
		end
	end

	// radius in q(F): sqrt(r2 << 2F)
	logic [RQ_W-1:0] root;
	rtm_isqrt #(.IN_W(SQ_W)) u_isqrt (
		.clk(clk), .ce(ce), .radicand({r2_s3, {(2 * F){1'b0}}}), .root(root)
	);

	// heading shaping: 4x^2y^2 / r^4 in q(F)
	logic [QB-1:0] quot;
	rtm_div #(.QB(QB)) u_div (
		.clk(clk), .ce(ce), .num(num_s4), .den(den_s4), .quot(quot)
	);

	// ---------------- alignment delays up to the join
	logic [RQ_W-1:0] rq_d [RQ_DLY];
	logic [QB-1:0]   qt_d [QT_DLY];
	cmd_t            cmd_d [CMD_DLY];
	cmd_t            cmd_s1;

	assign cmd_s1 = '{x: x_s1, y: y_s1, yaw: yaw_s1, up: up_s1, claw: claw_s1, dz: dz_s1};

	always_ff @(posedge clk) begin
		if (ce) begin
			rq_d[0]  <= root;
			qt_d[0]  <= quot;
			cmd_d[0] <= cmd_s1;
			for (int i = 1; i < RQ_DLY; i++)
				rq_d[i] <= rq_d[i-1];
			for (int i = 1; i < QT_DLY; i++)
				qt_d[i] <= qt_d[i-1];
			for (int i = 1; i < CMD_DLY; i++)
				cmd_d[i] <= cmd_d[i-1];
		end
	end

	// ---------------- stage 32: angle to signed weight d = 1 - 2*theta/pi
	localparam logic [31:0] QUARTER = 32'h4000_0000;
	localparam logic [31:0] HALF    = 32'h8000_0000;

	function automatic logic signed [F+2:0] weight(input rtm_pkg::ang_t z, input logic neg);
		logic [31:0] zc, zr;
		logic [F+1:0] q;
		if (z[rtm_pkg::ANG_W-1])
			zc = '0;
		else if (32'(z) > QUARTER)
			zc = QUARTER;
		else
			zc = 32'(z);
		zr = neg ? HALF - zc : zc;
		q  = zr[31 -: F + 2];
		return (F + 3)'(1 << F) - $signed({1'b0, q});
	endfunction

	logic signed [F+2:0] wa, wb;
	logic [F:0]          mag_a_s32, mag_b_s32;
	logic                sgn_a_s32, sgn_b_s32;

	assign wa = weight(ang_a, neg_a);
	assign wb = weight(ang_b, neg_b);

	always_ff @(posedge clk) begin
		if (ce) begin
			sgn_a_s32 <= wa[F+2];
			sgn_b_s32 <= wb[F+2];
			mag_a_s32 <= wa[F+2] ? (F + 1)'(-wa) : (F + 1)'(wa);
			mag_b_s32 <= wb[F+2] ? (F + 1)'(-wb) : (F + 1)'(wb);
		end
	end

	// ---------------- stages 33, 34: |d| * r, then * s
	logic [P1_W-1:0]  p1_a_s33, p1_b_s33;
	logic [SQ2_W-1:0] sq_s33;
	logic             sgn_a_s33, sgn_b_s33, sgn_a_s34, sgn_b_s34;
	logic [P2_W-1:0]  p2_a_s34, p2_b_s34;

	always_ff @(posedge clk) begin
		if (ce) begin
			p1_a_s33  <= P1_W'(mag_a_s32) * P1_W'(rq_d[RQ_DLY-1]);
			p1_b_s33  <= P1_W'(mag_b_s32) * P1_W'(rq_d[RQ_DLY-1]);
			sq_s33    <= SQ2_W'(1 << (F + 1)) - SQ2_W'(qt_d[QT_DLY-1]);
			sgn_a_s33 <= sgn_a_s32;
			sgn_b_s33 <= sgn_b_s32;
			p2_a_s34  <= P2_W'(p1_a_s33) * P2_W'(sq_s33);
			p2_b_s34  <= P2_W'(p1_b_s33) * P2_W'(sq_s33);
			sgn_a_s34 <= sgn_a_s33;
			sgn_b_s34 <= sgn_b_s33;
		end
	end

	// ---------------- stage 35: mix and centre
	cmd_t                c34;
	logic signed [13:0]  ta, tb, yaw_e, up_e, x_e, y_e, vt, claw_e;
	logic signed [13:0]  fl, fr, bl, br;
	logic signed [13:0]  ch [7];
	logic [12:0]         prod_a, prod_b;
	localparam logic signed [13:0] CTR  = 14'(rtm_pkg::CENTRE_PW);
	localparam logic signed [13:0] IDLE = 14'(rtm_pkg::IDLE_PW);

	assign c34    = cmd_d[CMD_DLY-1];
	assign prod_a = p2_a_s34[3 * F +: 13];
	assign prod_b = p2_b_s34[3 * F +: 13];

	always_comb begin
		yaw_e  = 14'(c34.yaw);
		up_e   = 14'(c34.up);
		x_e    = 14'(c34.x);
		y_e    = 14'(c34.y);
		claw_e = 14'(c34.claw);
		ta     = c34.dz ? '0 : (sgn_a_s34 ? -$signed({1'b0, prod_a}) : $signed({1'b0, prod_a}));
		tb     = c34.dz ? '0 : (sgn_b_s34 ? -$signed({1'b0, prod_b}) : $signed({1'b0, prod_b}));
		fl     = sat400(ta + yaw_e);
		fr     = sat400(tb - yaw_e);
		bl     = sat400(tb + yaw_e);
		br     = sat400(ta - yaw_e);
		vt     = sat400(up_e);
		if (!vtype_q) begin
			// vectored thrusters about the 1500 centre
			ch[0] = CTR - bl;
			ch[1] = CTR + vt;
			ch[2] = CTR + claw_e;
			ch[3] = CTR - fr;
			ch[4] = CTR - br;
			ch[5] = CTR - vt;
			ch[6] = CTR - fl;
		end else begin
			// differential drive about 400
			ch[0] = IDLE + sat400(x_e - y_e);
			ch[1] = IDLE + sat400(-(x_e + y_e));
			ch[2] = IDLE - vt;
			ch[3] = IDLE + vt;
			ch[4] = IDLE + sat400(-yaw_e);
			ch[5] = IDLE;
			ch[6] = IDLE;
		end
	end

	logic [rtm_pkg::OUT_W-1:0] out_s35 [7];

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 7; i++)
				out_s35[i] <= ch[i][rtm_pkg::OUT_W-1:0];
		end
	end

	assign m_tdata = {3'b000, out_s35[6], out_s35[5], out_s35[4], out_s35[3],
	                  out_s35[2], out_s35[1], out_s35[0]};

endmodule
